@@ hdl/ogu_pkg.sv @@
// Shared constants, codes and types of the occupancy grid update block.
`timescale 1ns / 1ps
`default_nettype none
package ogu_pkg;

   localparam int GRID_SIDE   = 256;
   localparam int TABLE_DEPTH = 32768;
   localparam int CELL_COUNT  = GRID_SIDE * GRID_SIDE;
   localparam int CELL_AW     = $clog2(CELL_COUNT);
   localparam int TABLE_AW    = $clog2(TABLE_DEPTH);

   localparam int LEVEL_W = 15;
   localparam int COORD_W = 8;
   localparam int KIND_W  = 3;

   // stored cell word: written flag on top of the level
   localparam int CELL_W  = LEVEL_W + 1;
   localparam int TABLE_W = 2 * LEVEL_W;

   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 16;
   localparam int RSP_USER_W = 2;

   localparam logic [LEVEL_W-1:0] LEVEL_COUNT_RESET = 15'd10000;

   typedef enum logic [KIND_W-1:0] {
      KIND_HIT        = 3'd0,
      KIND_MISS       = 3'd1,
      KIND_QUERY      = 3'd2,
      KIND_CLEAR_MARK = 3'd3,
      KIND_LOAD_TABLE = 3'd4,
      KIND_WRITE_CELL = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      SW_IDLE  = 3'b001,
      SW_CELLS = 3'b010,
      SW_MARKS = 3'b100
   } sweep_state_type;

   typedef struct packed {
      logic               busy;
      logic               cells;
      logic [CELL_AW-1:0] addr;
   } sweep_stat_type;

   typedef struct packed {
      logic               written;
      logic [LEVEL_W-1:0] level;
      logic               mark;
   } cell_view_type;

endpackage
`default_nettype wire

@@ hdl/ogu_ram.sv @@
// Generic simple dual-port RAM, one write port, one registered read port (read-first).
`timescale 1ns / 1ps
`default_nettype none
module ogu_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

@@ hdl/ogu_sweep.sv @@
// Address sweeper that clears the cell store after reset and the marks on request.
`timescale 1ns / 1ps
`default_nettype none
module ogu_sweep
   import ogu_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     start,
   output sweep_stat_type stat
);

   sweep_state_type    state_ff, state_in;
   logic [CELL_AW-1:0] addr_ff, addr_in;
   logic               last;

   assign last = (addr_ff == CELL_AW'(CELL_COUNT - 1));

   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      unique case (state_ff)
         SW_IDLE: begin
            addr_in = '0;
            if (start) begin
               state_in = SW_MARKS;
            end
         end
         SW_CELLS, SW_MARKS: begin
            addr_in = addr_ff + 1'b1;
            if (last) begin
               state_in = SW_IDLE;
               addr_in  = '0;
            end
         end
         default: begin
            state_in = SW_IDLE;
            addr_in  = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SW_CELLS;
         addr_ff  <= '0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
      end
   end

   assign stat.busy  = (state_ff != SW_IDLE);
   assign stat.cells = (state_ff == SW_CELLS);
   assign stat.addr  = addr_ff;

endmodule
`default_nettype wire

@@ hdl/occupancy_grid_hit_miss_update.sv @@
// Top level of the occupancy grid hit/miss update block.
`timescale 1ns / 1ps
`default_nettype none
// Occupancy grid update: a GRID_SIDE x GRID_SIDE grid of 15-bit levels with a
// written flag and a mark bit per cell, plus hit and miss next-level tables.
// Items enter on req_*, each gives exactly one result on rsp_*. The block runs
// a three-step read-modify-write pipeline: the cell word and mark are read
// from block RAM on acceptance, the next step resolves the cell (forwarding
// the two most recent cell writes) and reads the hit/miss table, the last step
// forms the result and writes back. One item is taken per clock while
// req_tready is high; it is low under rsp_tready backpressure, during a sweep
// and while a clear-marks item is in flight. Items pass the s1, s2 and output
// registers under one advance enable, so backpressure holds every step.
// Back-to-back hits on the same cell are handled by forwarding, a table load
// followed by a lookup of the same slot too. After reset req_tready stays low
// while the cell store is cleared; a clear-marks item likewise blocks intake
// while the mark RAM is swept. The user must write level_count through
// csr_we/csr_wdata only while the block is idle; the block does not enforce it.
module occupancy_grid_hit_miss_update
   import ogu_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [LEVEL_W-1:0]    csr_wdata,   // level_count
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   // cell_x[7:0], cell_y[15:8], table_slot[30:16], hit_next[45:31],
   // miss_next[60:46], cell_level[75:61], zero pad [79:76]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic [KIND_W-1:0]     req_tuser,   // kind[2:0]
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   output      logic [RSP_DATA_W-1:0] rsp_tdata,   // level[14:0], zero pad [15]
   output      logic [RSP_USER_W-1:0] rsp_tuser    // unknown[0], was_marked[1]
);

   // ---------------- configuration ----------------
   logic [LEVEL_W-1:0] lc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lc_ff <= LEVEL_COUNT_RESET;
      end else if (csr_we) begin
         lc_ff <= csr_wdata;
      end
   end

   // ---------------- input unpack ----------------
   logic [COORD_W-1:0] req_x, req_y;
   logic [LEVEL_W-1:0] req_slot, req_hn, req_mn, req_cl;
   logic               req_inside;
   logic [CELL_AW-1:0] req_addr;

   assign req_x    = req_tdata[7:0];
   assign req_y    = req_tdata[15:8];
   assign req_slot = req_tdata[30:16];
   assign req_hn   = req_tdata[45:31];
   assign req_mn   = req_tdata[60:46];
   assign req_cl   = req_tdata[75:61];

   assign req_inside = (32'(req_x) < GRID_SIDE) && (32'(req_y) < GRID_SIDE);
   assign req_addr   = CELL_AW'(32'(req_y) * GRID_SIDE + 32'(req_x));

   // ---------------- pipeline control ----------------
   logic           rsp_valid_ff, rsp_valid_in;
   logic           adv, accept;
   sweep_stat_type sweep;
   logic           sweep_start;

   logic               s1_valid_ff;
   kind_type           s1_kind_ff;
   logic               s1_inside_ff;
   logic [CELL_AW-1:0] s1_addr_ff;
   logic [LEVEL_W-1:0] s1_slot_ff, s1_hn_ff, s1_mn_ff, s1_cl_ff;

   logic               s2_valid_ff;
   kind_type           s2_kind_ff;
   logic               s2_inside_ff;
   logic [CELL_AW-1:0] s2_addr_ff;
   logic [LEVEL_W-1:0] s2_slot_ff, s2_hn_ff, s2_mn_ff, s2_cl_ff;
   cell_view_type      s2_view_ff;
   logic               s2_tfwd_ff;
   logic [TABLE_W-1:0] s2_tdata_ff;

   // whole pipeline moves when the output register is free
   assign adv = !rsp_valid_ff || rsp_tready;

   // a clear in flight must finish its sweep before any later item reads marks
   assign req_tready = adv && !sweep.busy
                       && !(s1_valid_ff && (s1_kind_ff == KIND_CLEAR_MARK))
                       && !(s2_valid_ff && (s2_kind_ff == KIND_CLEAR_MARK));
   assign accept = req_tvalid && req_tready;

   assign sweep_start = adv && s2_valid_ff && (s2_kind_ff == KIND_CLEAR_MARK);

   ogu_sweep u_sweep (
      .clock (clock),
      .reset (reset),
      .start (sweep_start),
      .stat  (sweep)
   );

   // ---------------- memories ----------------
   logic               cell_we;
   logic [CELL_AW-1:0] cell_waddr;
   logic [CELL_W-1:0]  cell_wdata, cell_rdata;
   logic               mark_we, mark_wdata, mark_rdata;
   logic               tab_we;
   logic [TABLE_W-1:0] tab_rdata;
   logic [TABLE_AW-1:0] s1_idx;

   ogu_ram #(.WIDTH(CELL_W), .DEPTH(CELL_COUNT)) u_cell_ram (
      .clock (clock),
      .we    (cell_we),
      .waddr (cell_waddr),
      .wdata (cell_wdata),
      .re    (adv),
      .raddr (req_addr),
      .rdata (cell_rdata)
   );

   ogu_ram #(.WIDTH(1), .DEPTH(CELL_COUNT)) u_mark_ram (
      .clock (clock),
      .we    (mark_we),
      .waddr (cell_waddr),
      .wdata (mark_wdata),
      .re    (adv),
      .raddr (req_addr),
      .rdata (mark_rdata)
   );

   ogu_ram #(.WIDTH(TABLE_W), .DEPTH(TABLE_DEPTH)) u_table_ram (
      .clock (clock),
      .we    (tab_we),
      .waddr (s2_slot_ff[TABLE_AW-1:0]),
      .wdata ({s2_mn_ff, s2_hn_ff}),
      .re    (adv),
      .raddr (s1_idx),
      .rdata (tab_rdata)
   );

   // ---------------- step 2: result and write-back ----------------
   logic [TABLE_W-1:0] s2_tab;
   logic [LEVEL_W-1:0] s2_next, s2_cur;
   logic               s2_unk_cur, s2_hitmiss;
   logic               s2_cell_wr;
   cell_view_type      s2_wr_view;
   logic [LEVEL_W-1:0] res_level;
   logic               res_unknown, res_marked;

   assign s2_tab     = s2_tfwd_ff ? s2_tdata_ff : tab_rdata;
   assign s2_next    = (s2_kind_ff == KIND_HIT) ? s2_tab[LEVEL_W-1:0]
                                                : s2_tab[TABLE_W-1:LEVEL_W];
   assign s2_cur     = s2_view_ff.written ? s2_view_ff.level : lc_ff;
   assign s2_unk_cur = !s2_view_ff.written || (s2_cur == lc_ff);
   assign s2_hitmiss = (s2_kind_ff == KIND_HIT) || (s2_kind_ff == KIND_MISS);

   // a write that this item will make when it leaves (not gated by adv)
   assign s2_cell_wr = s2_valid_ff && s2_inside_ff
                       && ((s2_hitmiss && !s2_view_ff.mark)
                           || (s2_kind_ff == KIND_WRITE_CELL));
   assign s2_wr_view.written = 1'b1;
   assign s2_wr_view.level   = s2_hitmiss ? s2_next : s2_cl_ff;
   assign s2_wr_view.mark    = s2_hitmiss;

   assign tab_we = adv && s2_valid_ff && (s2_kind_ff == KIND_LOAD_TABLE)
                   && (32'(s2_slot_ff) < TABLE_DEPTH);

   // sweep owns the write ports while it runs; the pipeline is empty then
   always_comb begin
      if (sweep.busy) begin
         cell_we    = sweep.cells;
         cell_waddr = sweep.addr;
         cell_wdata = '0;
         mark_we    = 1'b1;
         mark_wdata = 1'b0;
      end else begin
         cell_we    = adv && s2_cell_wr;
         cell_waddr = s2_addr_ff;
         cell_wdata = {s2_wr_view.written, s2_wr_view.level};
         mark_we    = adv && s2_cell_wr;
         mark_wdata = s2_wr_view.mark;
      end
   end

   always_comb begin
      res_level   = '0;
      res_unknown = 1'b0;
      res_marked  = 1'b0;
      unique case (s2_kind_ff)
         KIND_HIT, KIND_MISS: begin
            if (!s2_inside_ff) begin
               res_level   = lc_ff;
               res_unknown = 1'b1;
            end else if (s2_view_ff.mark) begin
               res_level   = s2_cur;
               res_unknown = s2_unk_cur;
               res_marked  = 1'b1;
            end else begin
               res_level   = s2_next;
               res_unknown = (s2_next == lc_ff);
            end
         end
         KIND_QUERY: begin
            if (!s2_inside_ff) begin
               res_level   = lc_ff;
               res_unknown = 1'b1;
            end else begin
               res_level   = s2_cur;
               res_unknown = s2_unk_cur;
            end
         end
         default: begin
            // clear marks, table load, cell write and unused kinds: all zero
         end
      endcase
   end

   // ---------------- last cell write, for reads that raced it ----------------
   logic               s3_valid_ff;
   logic [CELL_AW-1:0] s3_addr_ff;
   cell_view_type      s3_view_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (sweep.busy) begin
         s3_valid_ff <= 1'b0;
      end else if (adv && s2_cell_wr) begin
         s3_valid_ff <= 1'b1;
      end
      if (adv && s2_cell_wr) begin
         s3_addr_ff <= s2_addr_ff;
         s3_view_ff <= s2_wr_view;
      end
   end

   // ---------------- step 1: resolve cell and look up table ----------------
   cell_view_type      s1_view;
   logic [LEVEL_W-1:0] s1_cur, s1_clip;
   logic               s1_tfwd;

   always_comb begin
      priority if (s2_cell_wr && (s2_addr_ff == s1_addr_ff)) begin
         s1_view = s2_wr_view;
      end else if (s3_valid_ff && (s3_addr_ff == s1_addr_ff)) begin
         s1_view = s3_view_ff;
      end else begin
         s1_view.written = cell_rdata[CELL_W-1];
         s1_view.level   = cell_rdata[LEVEL_W-1:0];
         s1_view.mark    = mark_rdata;
      end
   end

   assign s1_cur  = s1_view.written ? s1_view.level : lc_ff;
   assign s1_clip = (s1_cur > lc_ff) ? lc_ff : s1_cur;
   assign s1_idx  = (32'(s1_clip) >= TABLE_DEPTH) ? TABLE_AW'(TABLE_DEPTH - 1)
                                                  : s1_clip[TABLE_AW-1:0];
   // table read is read-first: catch a load of the same slot at this edge
   assign s1_tfwd = tab_we && (s2_slot_ff[TABLE_AW-1:0] == s1_idx);

   // ---------------- pipeline registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= accept;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid_in = s2_valid_ff;

   logic [LEVEL_W-1:0] rsp_level_ff;
   logic               rsp_unknown_ff, rsp_marked_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_kind_ff   <= kind_type'(req_tuser);
         s1_inside_ff <= req_inside;
         s1_addr_ff   <= req_addr;
         s1_slot_ff   <= req_slot;
         s1_hn_ff     <= req_hn;
         s1_mn_ff     <= req_mn;
         s1_cl_ff     <= req_cl;

         s2_kind_ff   <= s1_kind_ff;
         s2_inside_ff <= s1_inside_ff;
         s2_addr_ff   <= s1_addr_ff;
         s2_slot_ff   <= s1_slot_ff;
         s2_hn_ff     <= s1_hn_ff;
         s2_mn_ff     <= s1_mn_ff;
         s2_cl_ff     <= s1_cl_ff;
         s2_view_ff   <= s1_view;
         s2_tfwd_ff   <= s1_tfwd;
         s2_tdata_ff  <= {s2_mn_ff, s2_hn_ff};

         rsp_level_ff   <= res_level;
         rsp_unknown_ff <= res_unknown;
         rsp_marked_ff  <= res_marked;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_level_ff};
   assign rsp_tuser  = {rsp_marked_ff, rsp_unknown_ff};

endmodule
`default_nettype wire

@@ hdl/ogu_checker.sv @@
// Port-level checker for the occupancy grid update block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module ogu_checker
   import ogu_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic [RSP_USER_W-1:0] rsp_tuser
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // store clearing pass starts right after reset: no intake
   a_reset_pass: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("item taken during reset clearing pass");

   // no result may appear out of reset
   a_reset_rsp: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // pad bit above the level stays zero
   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[RSP_DATA_W-1])
      else $error("result pad bit set");

endmodule

bind occupancy_grid_hit_miss_update ogu_checker u_ogu_checker (.*);
`default_nettype wire

@@ test/testbench.sv @@
// Self-checking testbench for the occupancy grid hit/miss update block.
`timescale 1ns / 1ps
//
// Flow:
//  - Items are generated in one initial block. Each item is run through the
//    grid predictor as it is generated, in the order the block will see it.
//    The item and its expected result then go into the pending queue.
//  - The driver takes items from the pending queue. On the accepting edge it
//    moves the expected result into grid_result_q.
//  - The monitor compares every accepted result, field by field, with the
//    oldest entry of grid_result_q.
//  - A hit or miss on an unmarked cell reads the hit/miss table at
//    min(level, level_count). A table slot that was never loaded must not be
//    read, so the generator first inserts a load of that slot when needed.
//  - level_count is written only while the block is idle. Each phase ends
//    with a query. A clear-marks item holds off intake for the whole sweep,
//    so the result of that query means the sweep is over.
//  - Idle rates: sender 31% / receiver 82%, then 82% / 31%, then none.
//    The last phase also has one long receiver hold-off. Phase 3 has one
//    item that the sender holds back until every outstanding result is in.
module testbench;
   import ogu_pkg::*;

   // tuser codes that the block treats as no operation
   localparam logic [KIND_W-1:0] KIND_SPARE_6 = 3'd6;
   localparam logic [KIND_W-1:0] KIND_SPARE_7 = 3'd7;

   localparam int POOL_SIZE   = 12;
   localparam int PHASE_ITEMS = 130;
   localparam int LONG_HOLD   = 400;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic               unknown;
      logic               was_marked;
   } grid_result_type;

   typedef struct {
      logic [KIND_W-1:0]  kind;
      logic [COORD_W-1:0] cx;
      logic [COORD_W-1:0] cy;
      logic [LEVEL_W-1:0] slot;
      logic [LEVEL_W-1:0] hnext;
      logic [LEVEL_W-1:0] mnext;
      logic [LEVEL_W-1:0] clevel;
      bit                 wait_drain;   // sender holds it until all results are in
      grid_result_type    res;          // expected result
   } grid_item_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  csr_we     = 1'b0;
   logic [LEVEL_W-1:0]    csr_wdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [KIND_W-1:0]     req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;

   // idle rates in percent and the long receiver hold-off
   int unsigned send_idle_pct = 31;
   int unsigned recv_idle_pct = 82;
   bit          hold_arm      = 1'b0;

   grid_item_type   pend_q[$];
   grid_result_type grid_result_q[$];
   int unsigned     grid_errors = 0;

   // grid predictor state
   logic [LEVEL_W-1:0] grid_level   [CELL_COUNT];
   bit                 grid_written [CELL_COUNT];
   bit                 grid_mark    [CELL_COUNT];
   logic [LEVEL_W-1:0] hit_next_tab [TABLE_DEPTH];
   logic [LEVEL_W-1:0] miss_next_tab[TABLE_DEPTH];
   bit                 tab_loaded   [TABLE_DEPTH];
   logic [LEVEL_W-1:0] cur_level_count = LEVEL_COUNT_RESET;

   bit [2*COORD_W-1:0] cell_pool[POOL_SIZE];

   occupancy_grid_hit_miss_update u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Apply one item to the predicted grid and return its result.
   function automatic grid_result_type predict_cell_update(input grid_item_type it);
      grid_result_type    r;
      logic [15:0]        a;
      logic [LEVEL_W-1:0] cur;
      logic [LEVEL_W-1:0] idx;
      logic [LEVEL_W-1:0] nxt;
      r   = '0;
      a   = {it.cy, it.cx};
      cur = grid_written[a] ? grid_level[a] : cur_level_count;
      case (it.kind)
         KIND_HIT, KIND_MISS: begin
            if (grid_mark[a]) begin
               // marked this pass: cell left alone, reported like a query
               r.level      = cur;
               r.unknown    = !grid_written[a] || cur == cur_level_count;
               r.was_marked = 1'b1;
            end else begin
               // clip to level_count; 15 bits never exceed the table depth
               idx = (cur > cur_level_count) ? cur_level_count : cur;
               nxt = (it.kind == KIND_HIT) ? hit_next_tab[idx] : miss_next_tab[idx];
               grid_level[a]   = nxt;
               grid_written[a] = 1'b1;
               grid_mark[a]    = 1'b1;
               r.level         = nxt;
               r.unknown       = (nxt == cur_level_count);
            end
         end
         KIND_QUERY: begin
            r.level   = cur;
            r.unknown = !grid_written[a] || cur == cur_level_count;
         end
         KIND_CLEAR_MARK: begin
            foreach (grid_mark[i]) grid_mark[i] = 1'b0;
         end
         KIND_LOAD_TABLE: begin
            hit_next_tab[it.slot]  = it.hnext;
            miss_next_tab[it.slot] = it.mnext;
            tab_loaded[it.slot]    = 1'b1;
         end
         KIND_WRITE_CELL: begin
            grid_level[a]   = it.clevel;
            grid_written[a] = 1'b1;
            grid_mark[a]    = 1'b0;
         end
         default: ;
      endcase
      return r;
   endfunction

   // Level values biased toward the interesting ones around level_count.
   function automatic logic [LEVEL_W-1:0] pick_level();
      logic [LEVEL_W-1:0] v;
      case ($urandom_range(4))
         0:       v = cur_level_count;
         1:       v = cur_level_count + 15'd1;
         2:       v = cur_level_count - 15'd1;
         3:       v = LEVEL_W'($urandom_range(15));
         default: v = LEVEL_W'($urandom_range(32767));
      endcase
      return v;
   endfunction

   // Item of the given kind and cell; the other request fields are random.
   function automatic grid_item_type make_item(input logic [KIND_W-1:0] kind,
                                               input logic [COORD_W-1:0] x,
                                               input logic [COORD_W-1:0] y);
      grid_item_type it;
      it.kind       = kind;
      it.cx         = x;
      it.cy         = y;
      it.slot       = LEVEL_W'($urandom_range(32767));
      it.hnext      = pick_level();
      it.mnext      = pick_level();
      it.clevel     = pick_level();
      it.wait_drain = 1'b0;
      it.res        = '0;
      return it;
   endfunction

   // Queue an item. A table slot that a lookup needs gets loaded first.
   function automatic void post_item(input grid_item_type it);
      grid_item_type      ld;
      logic [15:0]        a;
      logic [LEVEL_W-1:0] cur;
      logic [LEVEL_W-1:0] idx;
      a = {it.cy, it.cx};
      if ((it.kind == KIND_HIT || it.kind == KIND_MISS) && !grid_mark[a]) begin
         cur = grid_written[a] ? grid_level[a] : cur_level_count;
         idx = (cur > cur_level_count) ? cur_level_count : cur;
         if (!tab_loaded[idx]) begin
            ld      = make_item(KIND_LOAD_TABLE, it.cx, it.cy);
            ld.slot = idx;
            post_item(ld);
         end
      end
      it.res = predict_cell_update(it);
      pend_q.push_back(it);
   endfunction

   function automatic void post_load(input logic [LEVEL_W-1:0] slot,
                                     input logic [LEVEL_W-1:0] hn,
                                     input logic [LEVEL_W-1:0] mn);
      grid_item_type it;
      it       = make_item(KIND_LOAD_TABLE, 8'd0, 8'd0);
      it.slot  = slot;
      it.hnext = hn;
      it.mnext = mn;
      post_item(it);
   endfunction

   function automatic void post_write(input logic [COORD_W-1:0] x,
                                      input logic [COORD_W-1:0] y,
                                      input logic [LEVEL_W-1:0] lvl);
      grid_item_type it;
      it        = make_item(KIND_WRITE_CELL, x, y);
      it.clevel = lvl;
      post_item(it);
   endfunction

   // Checked at the falling edge, after the driver and the monitor have settled.
   task automatic wait_grid_idle();
      while (pend_q.size() != 0 || req_tvalid || grid_result_q.size() != 0)
         @(negedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_level_count(input logic [LEVEL_W-1:0] v);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      cur_level_count = v;
   endtask

   // Stimulus: directed items, then four random phases with different level_count.
   initial begin : stimulus
      grid_item_type      it;
      logic [KIND_W-1:0]  kind;
      logic [15:0]        addr;
      logic [LEVEL_W-1:0] lc_value;
      int unsigned        r;
      int unsigned        clear_at;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed part, level_count at its reset value
      post_item(make_item(KIND_QUERY, 8'd0, 8'd0));         // never written: unknown
      post_item(make_item(KIND_QUERY, 8'd255, 8'd255));
      post_load(LEVEL_COUNT_RESET, 15'd0, 15'h7FFF);
      post_item(make_item(KIND_HIT, 8'd0, 8'd0));           // unwritten reads as level_count
      post_item(make_item(KIND_HIT, 8'd0, 8'd0));           // same cell again: marked
      post_item(make_item(KIND_MISS, 8'd255, 8'd255));
      post_write(8'd255, 8'd0, 15'h7FFF);                   // above level_count
      post_item(make_item(KIND_HIT, 8'd255, 8'd0));         // clipped lookup
      post_write(8'd0, 8'd255, LEVEL_COUNT_RESET);          // written, still unknown
      post_item(make_item(KIND_QUERY, 8'd0, 8'd255));
      post_load(15'd0, LEVEL_COUNT_RESET, 15'd5);
      post_write(8'd1, 8'd1, 15'd0);
      post_item(make_item(KIND_HIT, 8'd1, 8'd1));           // next level is the unknown code
      post_write(8'd3, 8'd3, 15'd7);
      post_load(15'd7, 15'h2AAA, 15'h5555);
      post_item(make_item(KIND_MISS, 8'd3, 8'd3));          // lookup right behind its load
      post_write(8'd0, 8'd0, 15'd7);                        // write drops the mark
      post_item(make_item(KIND_HIT, 8'd0, 8'd0));
      post_item(make_item(KIND_MISS, 8'd255, 8'd255));      // still marked
      post_item(make_item(KIND_CLEAR_MARK, 8'd0, 8'd0));
      post_item(make_item(KIND_MISS, 8'd255, 8'd255));      // marks gone
      post_item(make_item(KIND_SPARE_6, 8'd255, 8'd255));
      post_item(make_item(KIND_SPARE_7, 8'd0, 8'd0));
      post_load(15'h7FFF, 15'h7FFF, 15'h7FFF);
      post_item(make_item(KIND_QUERY, 8'd255, 8'd255));

      for (int ph = 1; ph <= 4; ph++) begin
         wait_grid_idle();
         case (ph)
            1:       lc_value = 15'd100;
            2:       lc_value = 15'h7FFF;
            default: lc_value = LEVEL_W'($urandom_range(32767, 100));
         endcase
         set_level_count(lc_value);
         send_idle_pct <= (ph <= 1) ? 31 : (ph <= 3) ? 82 : 0;
         recv_idle_pct <= (ph <= 1) ? 82 : (ph <= 3) ? 31 : 0;
         if (ph == 4)
            hold_arm <= 1'b1;

         // small working set so hits, misses and writes collide on cells
         foreach (cell_pool[j]) cell_pool[j] = 16'($urandom);
         cell_pool[0] = 16'h0000;
         cell_pool[1] = 16'hFFFF;

         clear_at = $urandom_range(PHASE_ITEMS - 1);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            r = $urandom_range(99);
            if (i == clear_at)  kind = KIND_CLEAR_MARK;
            else if (r < 30)    kind = KIND_HIT;
            else if (r < 55)    kind = KIND_MISS;
            else if (r < 72)    kind = KIND_QUERY;
            else if (r < 86)    kind = KIND_WRITE_CELL;
            else if (r < 96)    kind = KIND_LOAD_TABLE;
            else if (r < 98)    kind = KIND_SPARE_6;
            else                kind = KIND_SPARE_7;
            if ($urandom_range(9) < 7)
               addr = cell_pool[$urandom_range(POOL_SIZE - 1)];
            else
               addr = 16'($urandom);
            it = make_item(kind, addr[7:0], addr[15:8]);
            if (kind == KIND_LOAD_TABLE && $urandom_range(1) == 1)
               it.slot = pick_level();
            it.wait_drain = (ph == 3 && i == PHASE_ITEMS / 2);
            post_item(it);
         end
         // its result means any mark sweep is finished
         post_item(make_item(KIND_QUERY, addr[7:0], addr[15:8]));
      end

      wait_grid_idle();
      if (grid_errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // Driver: offers pending items; valid stays up until the item is taken.
   always @(posedge clock) begin : req_driver
      grid_item_type cur_item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            grid_result_q.push_back(cur_item.res);
         if (!req_tvalid || req_tready) begin
            if (pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct &&
                !(pend_q[0].wait_drain && grid_result_q.size() != 0)) begin
               cur_item = pend_q.pop_front();
               req_tuser  <= cur_item.kind;
               req_tdata  <= {4'b0, cur_item.clevel, cur_item.mnext, cur_item.hnext,
                              cur_item.slot, cur_item.cy, cur_item.cx};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random ready, plus one long hold-off so the pipeline backs up.
   always @(posedge clock) begin : rsp_sink
      int unsigned hold_left;
      bit          hold_done;
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  = 0;
         hold_done  = 1'b0;
      end else if (hold_arm && !hold_done) begin
         hold_done  = 1'b1;
         hold_left  = LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Monitor: compares each accepted result with the oldest expected one.
   always @(posedge clock) begin : rsp_check
      grid_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (grid_result_q.size() == 0) begin
            $error("result with no item outstanding: tdata %h tuser %b",
                   rsp_tdata, rsp_tuser);
            grid_errors++;
         end else begin
            want = grid_result_q.pop_front();
            if (rsp_tdata[LEVEL_W-1:0] !== want.level) begin
               $error("level: expected %0d, got %0d", want.level, rsp_tdata[LEVEL_W-1:0]);
               grid_errors++;
            end
            if (rsp_tuser[0] !== want.unknown) begin
               $error("unknown: expected %0b, got %0b", want.unknown, rsp_tuser[0]);
               grid_errors++;
            end
            if (rsp_tuser[1] !== want.was_marked) begin
               $error("was_marked: expected %0b, got %0b", want.was_marked, rsp_tuser[1]);
               grid_errors++;
            end
         end
      end
   end

   // Timeout that outlasts the reset clear and the five mark sweeps.
   initial begin
      #12_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

@@ occupancy_grid_hit_miss_update.f @@
hdl/ogu_pkg.sv
hdl/ogu_ram.sv
hdl/ogu_sweep.sv
hdl/occupancy_grid_hit_miss_update.sv
hdl/ogu_checker.sv
test/testbench.sv
